FILE: rtl/spq_pkg.sv
// Shared types, codes and the string trimming function of the sorted priority queue.
package spq_pkg;

  localparam int STR_W = 64;
  localparam int ID_W = 32;
  localparam int OCC_W = 5;

  typedef enum logic [1:0] {
    REQ_INSERT,
    REQ_REMOVE,
    REQ_COUNT,
    REQ_LIST
  } req_t;

  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_EMPTY,
    STATUS_FULL
  } status_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,
    OP_REMOVE,
    OP_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     capture;
    logic     use_front;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } dp_status_t;

  // A string ends at its first zero byte and keeps at most nbytes bytes.
  function automatic logic [STR_W-1:0] cut_string(input logic [STR_W-1:0] s,
                                                  input int unsigned nbytes);
    logic [STR_W-1:0] r;
    logic             alive;
    r = '0;
    alive = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (s[STR_W-1-8*i -: 8] == 8'd0 || i >= nbytes) begin
        alive = 1'b0;
      end
      if (alive) begin
        r[STR_W-1-8*i -: 8] = s[STR_W-1-8*i -: 8];
      end
    end
    return r;
  endfunction

endpackage

FILE: rtl/spq_ctrl.sv
// Controller state machine of the sorted priority queue: request decode and list sequencing.
module spq_ctrl
  import spq_pkg::*;
#(
  parameter int DEPTH = 16,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [1:0]    req_type,
  input  dp_status_t    dp_status,
  input  logic [CW-1:0] count,
  output dp_cmd_t       cmd,
  output logic          busy,
  output logic          done,
  output logic [1:0]    status,
  output logic          last
);

  typedef enum logic {
    ST_IDLE,
    ST_LIST
  } state_t;

  state_t        state;
  logic [CW-1:0] remain;
  logic          accept;

  assign accept = start && (state == ST_IDLE);
  assign busy = (state == ST_LIST);

  always_comb begin
    cmd.op = OP_NONE;
    cmd.capture = 1'b0;
    cmd.use_front = 1'b0;
    if (state == ST_LIST) begin
      cmd.op = OP_ROTATE;
      cmd.capture = 1'b1;
      cmd.use_front = 1'b1;
    end else if (accept) begin
      cmd.capture = 1'b1;
      unique case (req_t'(req_type))
        REQ_INSERT: cmd.op = dp_status.full ? OP_NONE : OP_INSERT;
        REQ_REMOVE: begin
          cmd.op = dp_status.empty ? OP_NONE : OP_REMOVE;
          cmd.use_front = !dp_status.empty;
        end
        REQ_COUNT: cmd.op = OP_NONE;
        REQ_LIST: begin
          cmd.op = dp_status.empty ? OP_NONE : OP_ROTATE;
          cmd.use_front = !dp_status.empty;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done <= 1'b0;
      status <= STATUS_OK;
      last <= 1'b0;
      remain <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            done <= 1'b1;
            last <= 1'b1;
            status <= STATUS_OK;
            unique case (req_t'(req_type))
              REQ_INSERT: begin
                if (dp_status.full) begin
                  status <= STATUS_FULL;
                end
              end
              REQ_REMOVE: begin
                if (dp_status.empty) begin
                  status <= STATUS_EMPTY;
                end
              end
              REQ_COUNT: status <= STATUS_OK;
              REQ_LIST: begin
                if (dp_status.empty) begin
                  status <= STATUS_EMPTY;
                end else if (count != CW'(1)) begin
                  last <= 1'b0;
                  remain <= count - CW'(1);
                  state <= ST_LIST;
                end
              end
            endcase
          end
        end
        ST_LIST: begin
          done <= 1'b1;
          status <= STATUS_OK;
          if (remain == CW'(1)) begin
            last <= 1'b1;
            state <= ST_IDLE;
          end else begin
            last <= 1'b0;
            remain <= remain - CW'(1);
          end
        end
      endcase
    end
  end

endmodule

FILE: rtl/spq_datapath.sv
// Datapath of the sorted priority queue: a row of entry cells, the fill count and result registers.
module spq_datapath
  import spq_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int STRING_BYTES = 8,
  localparam int CW = $clog2(DEPTH + 1),
  localparam int SW = 8 * STRING_BYTES
) (
  input  logic                    clk,
  input  logic                    rst,
  input  dp_cmd_t                 cmd,
  input  logic signed [ID_W-1:0]  job_id,
  input  logic [STR_W-1:0]        job_name,
  input  logic [STR_W-1:0]        job_key,
  output dp_status_t              dp_status,
  output logic [CW-1:0]           count,
  output logic signed [ID_W-1:0]  out_id,
  output logic [STR_W-1:0]        out_name,
  output logic [STR_W-1:0]        out_key,
  output logic [OCC_W-1:0]        occupancy
);

  logic [SW-1:0]          key_q [DEPTH];
  logic [SW-1:0]          name_q [DEPTH];
  logic signed [ID_W-1:0] id_q [DEPTH];

  logic [SW-1:0]          dn_key [DEPTH];
  logic [SW-1:0]          dn_name [DEPTH];
  logic signed [ID_W-1:0] dn_id [DEPTH];
  logic [SW-1:0]          up_key [DEPTH];
  logic [SW-1:0]          up_name [DEPTH];
  logic signed [ID_W-1:0] up_id [DEPTH];

  logic [STR_W-1:0] key_cut;
  logic [STR_W-1:0] name_cut;
  logic [SW-1:0]  new_key;
  logic [SW-1:0]  new_name;
  logic [DEPTH-1:0] at_or_after;
  logic [DEPTH-1:0] take_new;
  logic [DEPTH-1:0] take_prev;
  logic [CW-1:0]  count_next;
  logic [CW-1:0]  tail;

  assign key_cut = cut_string(job_key, STRING_BYTES);
  assign name_cut = cut_string(job_name, STRING_BYTES);
  assign new_key = key_cut[STR_W-1 -: SW];
  assign new_name = name_cut[STR_W-1 -: SW];
  assign tail = count - CW'(1);

  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_link
    if (gi == 0) begin : g_head
      assign dn_key[gi] = new_key;
      assign dn_name[gi] = new_name;
      assign dn_id[gi] = job_id;
    end else begin : g_body
      assign dn_key[gi] = key_q[gi-1];
      assign dn_name[gi] = name_q[gi-1];
      assign dn_id[gi] = id_q[gi-1];
    end
    if (gi == DEPTH - 1) begin : g_tail
      assign up_key[gi] = key_q[gi];
      assign up_name[gi] = name_q[gi];
      assign up_id[gi] = id_q[gi];
    end else begin : g_inner
      assign up_key[gi] = key_q[gi+1];
      assign up_name[gi] = name_q[gi+1];
      assign up_id[gi] = id_q[gi+1];
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      at_or_after[i] = (CW'(i) >= count) || (new_key >= key_q[i]);
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (i == 0) begin
        take_new[i] = at_or_after[i];
        take_prev[i] = 1'b0;
      end else begin
        take_new[i] = at_or_after[i] && !at_or_after[i-1];
        take_prev[i] = at_or_after[i] && at_or_after[i-1];
      end
    end
  end

  always_comb begin
    unique case (cmd.op)
      OP_INSERT: count_next = count + CW'(1);
      OP_REMOVE: count_next = count - CW'(1);
      OP_NONE,
      OP_ROTATE: count_next = count;
    endcase
  end

  assign dp_status.empty = (count == '0);
  assign dp_status.full = (count == CW'(DEPTH));

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      unique case (cmd.op)
        OP_INSERT: begin
          if (take_new[i]) begin
            key_q[i] <= new_key;
            name_q[i] <= new_name;
            id_q[i] <= job_id;
          end else if (take_prev[i]) begin
            key_q[i] <= dn_key[i];
            name_q[i] <= dn_name[i];
            id_q[i] <= dn_id[i];
          end
        end
        OP_REMOVE: begin
          key_q[i] <= up_key[i];
          name_q[i] <= up_name[i];
          id_q[i] <= up_id[i];
        end
        OP_ROTATE: begin
          if (CW'(i) == tail) begin
            key_q[i] <= key_q[0];
            name_q[i] <= name_q[0];
            id_q[i] <= id_q[0];
          end else if (CW'(i) < tail) begin
            key_q[i] <= up_key[i];
            name_q[i] <= up_name[i];
            id_q[i] <= up_id[i];
          end
        end
        OP_NONE: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      occupancy <= OCC_W'(count_next);
      if (cmd.use_front) begin
        out_id <= id_q[0];
        out_name <= STR_W'(name_q[0]) << (STR_W - SW);
        out_key <= STR_W'(key_q[0]) << (STR_W - SW);
      end else begin
        out_id <= '0;
        out_name <= '0;
        out_key <= '0;
      end
    end
  end

endmodule

FILE: rtl/sorted_priority_queue_core.sv
// Top level of the sorted priority queue: controller and entry datapath.
//
// A request is taken at a rising edge with start high and busy low. req_type
// selects insert, remove front, count or list. Job fields matter only for an
// insert; name and key end at their first zero byte and keep STRING_BYTES bytes.
// Each result is shown for one cycle with done high, in the cycle after the
// request or after the previous result, and the receiver cannot stall.
// Insert, remove and count give one result each and busy stays low, so one
// such request can be taken every cycle. A list gives one result per stored
// entry, front to back, in consecutive cycles (one result with empty status if
// the queue is empty); busy is high until the final result.
// Each list step rotates the row of entry cells by one place. The last output
// marks the final result of a request. Reset empties the queue at once.
module sorted_priority_queue_core
  import spq_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int STRING_BYTES = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             req_type,
  input  logic signed [ID_W-1:0] job_id,
  input  logic [STR_W-1:0]       job_name,
  input  logic [STR_W-1:0]       job_key,
  output logic                   done,
  output logic [1:0]             status,
  output logic signed [ID_W-1:0] out_id,
  output logic [STR_W-1:0]       out_name,
  output logic [STR_W-1:0]       out_key,
  output logic [OCC_W-1:0]       occupancy,
  output logic                   last
);

  localparam int CW = $clog2(DEPTH + 1);

  dp_cmd_t       cmd;
  dp_status_t    dp_status;
  logic [CW-1:0] count;

  spq_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .dp_status(dp_status),
    .count    (count),
    .cmd      (cmd),
    .busy     (busy),
    .done     (done),
    .status   (status),
    .last     (last)
  );

  spq_datapath #(
    .DEPTH       (DEPTH),
    .STRING_BYTES(STRING_BYTES)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .job_id   (job_id),
    .job_name (job_name),
    .job_key  (job_key),
    .dp_status(dp_status),
    .count    (count),
    .out_id   (out_id),
    .out_name (out_name),
    .out_key  (out_key),
    .occupancy(occupancy)
  );

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> done)
    else $error("accepted item produced no result");

  a_list_continues: assert property (@(posedge clk) disable iff (rst)
    done && !last |=> done)
    else $error("list stream broke before its last result");

  a_full_occupancy: assert property (@(posedge clk) disable iff (rst)
    done && status == STATUS_FULL |-> occupancy == OCC_W'(DEPTH))
    else $error("full status with queue not full");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    done && status == STATUS_EMPTY |-> occupancy == '0 && out_key == '0 && last)
    else $error("empty status with entries or payload");

endmodule
